// ===== rtl/gnc_pkg.sv =====
package gnc_pkg;

  localparam int DEF_GRAD_WIDTH   = 16;
  localparam int DEF_MAX_ELEMENTS = 65536;

  localparam int NORM_W    = 24;
  localparam int THR_W     = 24;
  localparam int FACTOR_W  = 17;
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = FACTOR_W;

  localparam logic [THR_W-1:0]    THR_RESET = 24'd4096;
  localparam logic [FACTOR_W-1:0] UNITY     = 17'h10000;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_SCALE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SQRT,
    S_NORM,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic sqrt_step;
    logic norm;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic last;
    logic sqrt_done;
    logic div_needed;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/gnc_controller.sv =====
module gnc_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gnc_pkg::sts_t sts,
  output gnc_pkg::cmd_t cmd
);
  import gnc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (sts.action == ACT_ACCUM && sts.last) state_next = S_SQRT;
        else state_next = S_OUT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.div_needed) state_next = S_DIV;
        else state_next = S_OUT;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      S_MUL:  cmd.mul = 1'b1;
      S_ACC:  cmd.acc = 1'b1;
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_NORM: cmd.norm = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_OUT:  cmd.out_load = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  a_load_to_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_MUL)
    else $error("accepted item did not start its multiply");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_done) |=> state == S_OUT)
    else $error("division end did not lead to result load");

endmodule

// ===== rtl/gnc_datapath.sv =====
module gnc_datapath #(
  parameter int GRAD_WIDTH   = gnc_pkg::DEF_GRAD_WIDTH,
  parameter int MAX_ELEMENTS = gnc_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gnc_pkg::cmd_t                    cmd,
  output gnc_pkg::sts_t                    sts,
  input  logic                             in_action,
  input  logic signed [GRAD_WIDTH-1:0]     in_gradient,
  input  logic                             in_last,
  input  logic                             cfg_wr_en,
  input  logic [gnc_pkg::THR_W-1:0]        cfg_wr_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [GRAD_WIDTH-1:0]     out_gradient,
  output logic [gnc_pkg::NORM_W-1:0]       out_norm,
  output logic                             out_clip,
  output logic                             out_norm_ready
);
  import gnc_pkg::*;

  localparam int SUM_W    = 2 * GRAD_WIDTH - 1 + $clog2(MAX_ELEMENTS);
  localparam int SQ_W     = 2 * GRAD_WIDTH - 1;
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int MB_W     = ((GRAD_WIDTH > FACTOR_W) ? GRAD_WIDTH : FACTOR_W) + 1;
  localparam int PROD_W   = GRAD_WIDTH + MB_W;
  localparam int STEP_MAX = (ROOT_W > DIV_STEPS) ? ROOT_W : DIV_STEPS;
  localparam int CNT_W    = $clog2(STEP_MAX);

  logic                         action;
  logic signed [GRAD_WIDTH-1:0] grad;
  logic                         last;
  logic signed [PROD_W-1:0]     prod;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]     scaled;
  logic [SUM_W-1:0]             square_sum;
  logic [SUM_W:0]               sum_add;
  logic [SUM_W-1:0]             sum_sat;
  logic [THR_W-1:0]             clip_threshold;
  logic [NORM_W-1:0]            norm_value;
  logic [FACTOR_W-1:0]          scale_factor;
  logic                         clipping_on;
  logic signed [GRAD_WIDTH-1:0] result;
  logic                         ready_flag;
  logic [CNT_W-1:0]             cnt;
  logic [RAD_W-1:0]             rad;
  logic [REM_W-1:0]             sq_rem;
  logic [REM_W-1:0]             sq_rem_sh;
  logic [REM_W-1:0]             sq_trial;
  logic [ROOT_W-1:0]            root;
  logic [NORM_W-1:0]            root_norm;
  logic [NORM_W-1:0]            div_rem;
  logic [NORM_W:0]              div_trial;
  logic [DIV_STEPS-1:0]         div_bits;
  logic [FACTOR_W-1:0]          quot;
  logic [FACTOR_W-1:0]          quot_next;
  logic [NORM_W-1:0]            div_rem_next;

  assign mul_b = (action == ACT_SCALE) ? $signed({{(MB_W - FACTOR_W){1'b0}}, scale_factor})
                                       : MB_W'(grad);
  assign scaled  = prod >>> FRAC_W;
  assign sum_add = {1'b0, square_sum} + (SUM_W + 1)'(prod[SQ_W-1:0]);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  assign sq_rem_sh = {sq_rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign sq_trial  = REM_W'({root, 2'b01});
  assign root_norm = NORM_W'(root);

  assign div_trial = {div_rem, div_bits[DIV_STEPS-1]};
  always_comb begin
    if (div_trial >= {1'b0, norm_value}) begin
      div_rem_next = NORM_W'(div_trial - {1'b0, norm_value});
      quot_next    = {quot[FACTOR_W-2:0], 1'b1};
    end else begin
      div_rem_next = div_trial[NORM_W-1:0];
      quot_next    = {quot[FACTOR_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_action;
      grad   <= in_gradient;
      last   <= in_last;
    end
    if (cmd.mul) begin
      prod <= grad * mul_b;
    end
    if (cmd.acc) begin
      ready_flag <= (action == ACT_ACCUM) && last;
      if (action == ACT_SCALE && clipping_on) result <= scaled[GRAD_WIDTH-1:0];
      else result <= grad;
      if (action == ACT_ACCUM && last) begin
        rad    <= RAD_W'(sum_sat);
        sq_rem <= '0;
        root   <= '0;
        cnt    <= '0;
      end
    end
    if (cmd.sqrt_step) begin
      rad <= rad << 2;
      cnt <= cnt + 1'b1;
      if (sq_rem_sh >= sq_trial) begin
        sq_rem <= sq_rem_sh - sq_trial;
        root   <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_rem_sh;
        root   <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.norm) begin
      cnt      <= '0;
      div_rem  <= NORM_W'(clip_threshold >> 1);
      div_bits <= {clip_threshold[0], {FRAC_W{1'b0}}};
      quot     <= '0;
    end
    if (cmd.div_step) begin
      cnt      <= cnt + 1'b1;
      div_rem  <= div_rem_next;
      div_bits <= div_bits << 1;
      quot     <= quot_next;
    end
    if (cmd.out_load) begin
      out_gradient   <= result;
      out_norm       <= norm_value;
      out_clip       <= clipping_on;
      out_norm_ready <= ready_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      norm_value     <= '0;
      scale_factor   <= UNITY;
      clipping_on    <= 1'b0;
      clip_threshold <= THR_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) clip_threshold <= cfg_wr_data;
      if (cmd.acc && action == ACT_ACCUM) begin
        square_sum <= last ? '0 : sum_sat;
      end
      if (cmd.norm) begin
        norm_value <= root_norm;
        if (!sts.div_needed) begin
          scale_factor <= UNITY;
          clipping_on  <= 1'b0;
        end
      end
      if (cmd.div_step && sts.div_done) begin
        scale_factor <= quot_next;
        clipping_on  <= 1'b1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts            = '0;
    sts.action     = action;
    sts.last       = last;
    sts.sqrt_done  = cnt == CNT_W'(ROOT_W - 1);
    sts.div_needed = (root_norm != '0) && (root_norm >= clip_threshold);
    sts.div_done   = cnt == CNT_W'(DIV_STEPS - 1);
    sts.out_free   = !out_valid || out_ready;
  end

  a_unity_when_off: assert property (@(posedge clk) disable iff (rst)
    !clipping_on |-> scale_factor == UNITY)
    else $error("scale factor not unity while clipping is off");

  a_clip_needs_norm: assert property (@(posedge clk) disable iff (rst)
    clipping_on |-> norm_value != '0)
    else $error("clipping active with a zero norm");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc && action == ACT_ACCUM && last) |=> square_sum == '0)
    else $error("square sum not cleared after the last element");

endmodule

// ===== rtl/gradient_norm_clipper_unit.sv =====
// Gradient clipping by global L2 norm. Feed every gradient once with tuser = 0
// (accumulate) and tlast on the final one, then again with tuser = 1 (scale).
// Every item yields one result item. An accumulate or scale item goes from
// acceptance to its result register through input capture, one shared
// multiplier, the accumulate or scale step, and the result load. The last
// accumulate item additionally runs a one-bit-per-cycle square root over the
// sum (ROOT_W = (2*GRAD_WIDTH - 1 + clog2(MAX_ELEMENTS) + 1) / 2 result bits, 24
// by default), a step to store the norm, and, when clipping engages, a
// restoring division for the 17-bit factor. A finished result waits in the
// output register while the next item is accepted.
module gradient_norm_clipper_unit #(
  parameter int GRAD_WIDTH   = gnc_pkg::DEF_GRAD_WIDTH,
  parameter int MAX_ELEMENTS = gnc_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // gradient
  input  logic [((GRAD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                                   s_axis_tlast,
  // action
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // scaled_gradient, norm
  output logic [((GRAD_WIDTH + gnc_pkg::NORM_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                                   m_axis_tlast,
  // clip_active
  output logic                                   m_axis_tuser,
  input  logic                                   cfg_wr_en,
  input  logic [gnc_pkg::THR_W-1:0]              cfg_wr_data
);
  import gnc_pkg::*;

  localparam int OUT_W   = ((GRAD_WIDTH + NORM_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - GRAD_WIDTH - NORM_W;

  cmd_t                         cmd;
  sts_t                         sts;
  logic signed [GRAD_WIDTH-1:0] out_gradient;
  logic [NORM_W-1:0]            out_norm;

  gnc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gnc_datapath #(
    .GRAD_WIDTH   (GRAD_WIDTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (s_axis_tuser),
    .in_gradient    ($signed(s_axis_tdata[GRAD_WIDTH-1:0])),
    .in_last        (s_axis_tlast),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_gradient   (out_gradient),
    .out_norm       (out_norm),
    .out_clip       (m_axis_tuser),
    .out_norm_ready (m_axis_tlast)
  );

  generate
    if (OUT_PAD > 0) begin : g_pad
      assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_norm, out_gradient};
    end else begin : g_nopad
      assign m_axis_tdata = {out_norm, out_gradient};
    end
  endgenerate

endmodule
